### hw/rtl/fdpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_pkg
// Shared types, constants and the coil address map of the flip-dot driver.
// ----------------------------------------------------------------------------
package fdpd_pkg;

  localparam int SHADOW_DEPTH = 16384;
  localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);
  localparam int IDX_W        = 16;
  localparam logic [IDX_W:0] SHADOW_LIMIT = (IDX_W + 1)'(SHADOW_DEPTH);

  localparam logic [4:0] TABLE_SIZE = 5'd28;

  localparam logic [15:0] ADDR_SET_BITS = 16'h2000 | 16'h4000;
  localparam logic [15:0] ADDR_RST_BITS = 16'h8000;
  localparam logic [15:0] ADDR_ODD_BIT  = 16'h0080;

  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_PANEL_WIDTH  = 2'd0,
    REG_PANEL_HEIGHT = 2'd1,
    REG_PANEL_COUNT  = 2'd2,
    REG_STACKED      = 2'd3
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_FORCE = 1'b0,
    OP_FRAME = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_DIV,
    ST_FORM,
    ST_DRIVE,
    ST_RELEASE
  } fsm_state_t;

  typedef struct packed {
    logic [4:0] panel_width;
    logic [4:0] panel_height;
    logic [3:0] panel_count;
    logic       stacked;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic shadow_wr;
    logic div_step;
    logic load_out;
    logic release_word;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic oob;
    logic op_frame;
    logic idx_ok;
    logic same;
    logic div_done;
  } status_t;

  function automatic logic [4:0] addr_map(input logic [4:0] idx);
    logic [4:0] v;
    case (idx)
      5'd0:    v = 5'd16;
      5'd1:    v = 5'd8;
      5'd2:    v = 5'd24;
      5'd3:    v = 5'd4;
      5'd4:    v = 5'd20;
      5'd5:    v = 5'd12;
      5'd6:    v = 5'd28;
      5'd7:    v = 5'd18;
      5'd8:    v = 5'd10;
      5'd9:    v = 5'd26;
      5'd10:   v = 5'd6;
      5'd11:   v = 5'd22;
      5'd12:   v = 5'd14;
      5'd13:   v = 5'd30;
      5'd14:   v = 5'd17;
      5'd15:   v = 5'd9;
      5'd16:   v = 5'd25;
      5'd17:   v = 5'd5;
      5'd18:   v = 5'd21;
      5'd19:   v = 5'd13;
      5'd20:   v = 5'd29;
      5'd21:   v = 5'd19;
      5'd22:   v = 5'd11;
      5'd23:   v = 5'd27;
      5'd24:   v = 5'd7;
      5'd25:   v = 5'd23;
      5'd26:   v = 5'd15;
      5'd27:   v = 5'd31;
      default: v = 5'd16;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/fdpd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_req_if
// Dot request channel: valid/ready plus one dot request word.
// ----------------------------------------------------------------------------
interface fdpd_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] col_x;
  logic [5:0] row_y;
  logic       dot_on;

  modport source (output valid, opcode, col_x, row_y, dot_on, input ready);
  modport sink   (input valid, opcode, col_x, row_y, dot_on, output ready);
endinterface

### hw/rtl/fdpd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_rsp_if
// Drive word channel: valid/ready plus address, enable and last flag.
// ----------------------------------------------------------------------------
interface fdpd_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_address;
  logic [7:0]  drive_enable;
  logic        last;

  modport source (output valid, drive_address, drive_enable, last, input ready);
  modport sink   (input valid, drive_address, drive_enable, last, output ready);
endinterface

### hw/rtl/fdpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fdpd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/fdpd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_regs
// APB configuration registers: panel geometry and stacking mode.
// ----------------------------------------------------------------------------
module fdpd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fdpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output fdpd_pkg::cfg_t               cfg
);

  fdpd_pkg::reg_index_t sel;
  logic                 wr;

  assign pready = 1'b1;
  assign sel    = fdpd_pkg::reg_index_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width  <= 5'd28;
      cfg.panel_height <= 5'd28;
      cfg.panel_count  <= 4'd1;
      cfg.stacked      <= 1'b0;
    end else if (wr) begin
      case (sel)
        fdpd_pkg::REG_PANEL_WIDTH:  cfg.panel_width  <= pwdata[4:0];
        fdpd_pkg::REG_PANEL_HEIGHT: cfg.panel_height <= pwdata[4:0];
        fdpd_pkg::REG_PANEL_COUNT:  cfg.panel_count  <= pwdata[3:0];
        fdpd_pkg::REG_STACKED:      cfg.stacked      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      fdpd_pkg::REG_PANEL_WIDTH:  prdata = {27'd0, cfg.panel_width};
      fdpd_pkg::REG_PANEL_HEIGHT: prdata = {27'd0, cfg.panel_height};
      fdpd_pkg::REG_PANEL_COUNT:  prdata = {28'd0, cfg.panel_count};
      fdpd_pkg::REG_STACKED:      prdata = {31'd0, cfg.stacked};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/fdpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_ctrl
// Sequencer: shadow clear, bounds check, shadow compare, panel divide,
// drive word and release word.
// ----------------------------------------------------------------------------
module fdpd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  output logic                rsp_last,
  input  logic                rsp_ready,
  input  fdpd_pkg::status_t   status,
  output fdpd_pkg::cmd_t      cmd
);

  fdpd_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdpd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fdpd_pkg::ST_CLEAR: begin
        if (status.clr_done) state_next = fdpd_pkg::ST_IDLE;
      end
      fdpd_pkg::ST_IDLE: begin
        if (req_valid) state_next = fdpd_pkg::ST_CHECK;
      end
      fdpd_pkg::ST_CHECK: begin
        if (status.oob) begin
          state_next = fdpd_pkg::ST_IDLE;
        end else if (status.op_frame && status.idx_ok) begin
          state_next = fdpd_pkg::ST_READ;
        end else begin
          state_next = fdpd_pkg::ST_DIV;
        end
      end
      fdpd_pkg::ST_READ: begin
        state_next = status.same ? fdpd_pkg::ST_IDLE : fdpd_pkg::ST_DIV;
      end
      fdpd_pkg::ST_DIV: begin
        if (status.div_done) state_next = fdpd_pkg::ST_FORM;
      end
      fdpd_pkg::ST_FORM: begin
        state_next = fdpd_pkg::ST_DRIVE;
      end
      fdpd_pkg::ST_DRIVE: begin
        if (rsp_ready) state_next = fdpd_pkg::ST_RELEASE;
      end
      fdpd_pkg::ST_RELEASE: begin
        if (rsp_ready) state_next = fdpd_pkg::ST_IDLE;
      end
      default: state_next = fdpd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    rsp_last  = 1'b0;
    case (state)
      fdpd_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      fdpd_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      fdpd_pkg::ST_CHECK: ;
      fdpd_pkg::ST_READ: cmd.shadow_wr = ~status.same;
      fdpd_pkg::ST_DIV:  cmd.div_step  = ~status.div_done;
      fdpd_pkg::ST_FORM: cmd.load_out  = 1'b1;
      fdpd_pkg::ST_DRIVE: rsp_valid = 1'b1;
      fdpd_pkg::ST_RELEASE: begin
        rsp_valid        = 1'b1;
        rsp_last         = 1'b1;
        cmd.release_word = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/fdpd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpd_dp
// Datapath: request registers, bounds and shadow index, shadow frame RAM,
// panel divider and drive word former.
// ----------------------------------------------------------------------------
module fdpd_dp (
  input  logic              clk,
  input  logic              rst,
  input  fdpd_pkg::cfg_t    cfg,
  input  fdpd_pkg::cmd_t    cmd,
  output fdpd_pkg::status_t status,
  input  logic              in_opcode,
  input  logic [7:0]        in_col_x,
  input  logic [5:0]        in_row_y,
  input  logic              in_dot_on,
  output logic [15:0]       drive_address,
  output logic [7:0]        drive_enable
);

  // request word
  logic       op_r;
  logic [7:0] x_r;
  logic [5:0] y_r;
  logic       on_r;

  // geometry
  logic [4:0] pw;
  logic [4:0] ph;
  logic [8:0] w;
  logic [5:0] h;
  logic [fdpd_pkg::IDX_W-1:0] idx;

  // shadow frame
  logic [fdpd_pkg::SHADOW_AW-1:0] clr_cnt;
  logic [fdpd_pkg::SHADOW_AW-1:0] ram_addr;
  logic                           ram_we;
  logic                           ram_wdata;
  logic                           ram_rdata;

  // divider
  logic [7:0] rem;
  logic [3:0] panel;

  // drive word
  logic        top;
  logic [4:0]  pnl;
  logic [4:0]  lx;
  logic [5:0]  ty_full;
  logic [4:0]  ty;
  logic [4:0]  tx;
  logic [4:0]  mx;
  logic [4:0]  my;
  logic [15:0] addr_word;
  logic [7:0]  en_word;
  logic [15:0] drv_addr;
  logic [7:0]  drv_en;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      x_r  <= in_col_x;
      y_r  <= in_row_y;
      on_r <= in_dot_on;
    end
  end

  assign pw  = (cfg.panel_width  > fdpd_pkg::TABLE_SIZE) ? fdpd_pkg::TABLE_SIZE
                                                          : cfg.panel_width;
  assign ph  = (cfg.panel_height > fdpd_pkg::TABLE_SIZE) ? fdpd_pkg::TABLE_SIZE
                                                          : cfg.panel_height;
  assign w   = 9'(pw) * 9'(cfg.panel_count);
  assign h   = cfg.stacked ? {ph, 1'b0} : {1'b0, ph};
  assign idx = fdpd_pkg::IDX_W'(y_r) * fdpd_pkg::IDX_W'(w)
             + fdpd_pkg::IDX_W'(x_r);

  assign status.oob      = (pw == 5'd0) || ({1'b0, x_r} >= w) || (y_r >= h);
  assign status.op_frame = (op_r == fdpd_pkg::OP_FRAME);
  assign status.idx_ok   = {1'b0, idx} < fdpd_pkg::SHADOW_LIMIT;
  assign status.same     = (ram_rdata == on_r);
  assign status.div_done = (rem < {3'b000, pw});
  assign status.clr_done =
    (clr_cnt == fdpd_pkg::SHADOW_AW'(fdpd_pkg::SHADOW_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign ram_addr  = cmd.clr_step ? clr_cnt : idx[fdpd_pkg::SHADOW_AW-1:0];
  assign ram_we    = cmd.clr_step | cmd.shadow_wr;
  assign ram_wdata = cmd.clr_step ? 1'b0 : on_r;

  fdpd_ram #(
    .WIDTH (1),
    .DEPTH (fdpd_pkg::SHADOW_DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // repeated subtraction: one panel width per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= in_col_x;
      panel <= 4'd0;
    end else if (cmd.div_step) begin
      rem   <= rem - {3'b000, pw};
      panel <= panel + 4'd1;
    end
  end

  always_comb begin
    top     = (y_r < {1'b0, ph});
    pnl     = {1'b0, panel};
    lx      = rem[4:0];
    ty_full = y_r;
    if (cfg.stacked) begin
      if (top) begin
        pnl     = {panel, 1'b1};
        lx      = pw - rem[4:0] - 5'd1;
        ty_full = {1'b0, ph} - y_r - 6'd1;
      end else begin
        pnl     = {panel, 1'b0};
        ty_full = y_r - {1'b0, ph};
      end
    end
    ty = (ty_full < {1'b0, fdpd_pkg::TABLE_SIZE}) ? ty_full[4:0] : 5'd0;
    tx = (lx < fdpd_pkg::TABLE_SIZE) ? lx : 5'd0;
    mx = fdpd_pkg::addr_map(tx);
    my = fdpd_pkg::addr_map(ty);
    addr_word = {3'b000, mx, 8'h00} | {9'd0, my, 2'b00};
    if (mx[0]) addr_word = addr_word | fdpd_pkg::ADDR_ODD_BIT;
    if (on_r) begin
      addr_word = addr_word | fdpd_pkg::ADDR_SET_BITS;
    end else begin
      addr_word = addr_word | fdpd_pkg::ADDR_RST_BITS;
    end
    en_word = (pnl < 5'd8) ? (8'd1 << pnl[2:0]) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      drv_addr <= addr_word;
      drv_en   <= en_word;
    end
  end

  assign drive_address = cmd.release_word ? 16'd0 : drv_addr;
  assign drive_enable  = cmd.release_word ? 8'd0  : drv_en;

endmodule

### hw/rtl/flip_dot_pixel_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flip_dot_pixel_driver
// Turns dot requests into a coil drive word and a release word per dot.
//
//   channel  dir  handshake        word
//   req      in   valid/ready      opcode, col_x, row_y, dot_on
//   rsp      out  valid/ready      drive_address, drive_enable, last
//   apb      in   psel/penable     panel_width, panel_height, panel_count,
//                                  stacked at 0x0, 0x4, 0x8, 0xC
//
// One request at a time. Out of bounds or unchanged frame dot: no word.
// A driven dot passes the bounds check, a shadow read for a frame request
// with an in-range index, one subtract step per panel crossed by the divider
// and the word former; the drive and release words each wait while rsp stalls.
// After reset the shadow frame RAM is cleared one entry per cycle;
// req stays not ready until then, APB works throughout.
// ----------------------------------------------------------------------------
module flip_dot_pixel_driver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fdpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  fdpd_req_if.sink                     req,
  fdpd_rsp_if.source                   rsp
);

  fdpd_pkg::cfg_t    cfg;
  fdpd_pkg::cmd_t    cmd;
  fdpd_pkg::status_t status;

  fdpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_last  (rsp.last),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fdpd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (req.opcode),
    .in_col_x      (req.col_x),
    .in_row_y      (req.row_y),
    .in_dot_on     (req.dot_on),
    .drive_address (rsp.drive_address),
    .drive_enable  (rsp.drive_enable)
  );

endmodule
